>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on clk_i, quiet while rst_ni is low.
`define BSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bsd3 assertion failed");
// Same with an explicit clock and active-low reset.
`define BSD_ASSERT_CR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bsd3 assertion failed");
`else
`define BSD_ASSERT(lbl, prop)
`define BSD_ASSERT_CR(lbl, clk, rstn, prop)
`endif

`endif

>>> src/bsd3_pkg.sv
package bsd3_pkg;

  // Data and geometry
  localparam int SAMPLE_W = 16;
  localparam int MAX_SIZE = 64;
  localparam int ADDR_W   = $clog2(MAX_SIZE);
  localparam int SIZE_W   = 7;
  localparam int THR_W    = 16;
  localparam int MIN_SIZE = 3;

  // Column weight t + 4m + b needs SAMPLE_W + 3 bits; full sum SAMPLE_W + 6
  localparam int COLW_W = SAMPLE_W + 3;
  localparam int SUM_W  = SAMPLE_W + 6;

  // Divide by 36: drop two bits, then multiply by ceil(2^23 / 9) and shift
  localparam int QIN_W      = SUM_W - 2;
  localparam int DIV9_SHIFT = 23;
  localparam int DIV9_MUL_W = 20;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 20'd932068;
  localparam int PROD_W = QIN_W + DIV9_MUL_W;

  // Configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_e;

  // One window column, top row first
  typedef struct packed {
    logic [SAMPLE_W-1:0] top;
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] bot;
  } col_t;

  // Line store word: row two above and row directly above
  typedef struct packed {
    logic [SAMPLE_W-1:0] older;
    logic [SAMPLE_W-1:0] prev;
  } line_word_t;

  // Kernel column 1,4,1; the center column is this times four
  function automatic logic [COLW_W-1:0] col_weight(input col_t c);
    logic [COLW_W-1:0] t;
    logic [COLW_W-1:0] m;
    logic [COLW_W-1:0] b;
    t = COLW_W'(c.top);
    m = COLW_W'(c.mid);
    b = COLW_W'(c.bot);
    return t + (m << 2) + b;
  endfunction

endpackage

>>> src/bsd3_line_buf.sv
module bsd3_line_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [bsd3_pkg::ADDR_W-1:0] rd_addr_i,
  input  logic                   wr_en_i,
  input  logic [bsd3_pkg::ADDR_W-1:0] wr_addr_i,
  input  bsd3_pkg::line_word_t   wr_data_i,
  output bsd3_pkg::line_word_t   rd_data_o
);
  import bsd3_pkg::*;

  line_word_t mem [MAX_SIZE];
  line_word_t rd_q;
  line_word_t fwd_data_q;
  logic       fwd_q;

  // Storage: one write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Bypass when the word is written in the same cycle it is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

>>> src/bsd3_col_cell.sv
module bsd3_col_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  bsd3_pkg::col_t              col_i,
  output bsd3_pkg::col_t              col_o,
  output logic [bsd3_pkg::COLW_W-1:0] wsum_o
);
  import bsd3_pkg::*;

  col_t col_q;

  // Take the neighbor's column on each word that passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o  = col_q;
  assign wsum_o = col_weight(col_q);

endmodule

>>> src/binomial_smooth_decimate_3x3_core.sv
// Pipeline: the word that completes a window (sample at row i+1, column j+1) passes
// through stage 1, stage 2 (weighted sum), stage 3 (multiply) and the output register.
// Throughput: one sample per cycle while the output is not stalled; line store read,
// window shift and the divide-by-36 multiplier are each one pipeline stage.
// Reset: asynchronous active low; clears position counters, window columns and
// valid bits, grid_size to 64, threshold to 0. Line stores are not cleared.
`include "assert_macros.svh"

module binomial_smooth_decimate_3x3_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bsd3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsd3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bsd3_pkg::SAMPLE_W-1:0]   s_axis_tdata,  // [15:0] sample
  input  logic                            s_axis_tuser,  // [0] frame_start
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bsd3_pkg::SAMPLE_W-1:0]   m_axis_tdata,  // [15:0] smoothed
  output logic                            m_axis_tlast,  // last_in_row
  output logic [1:0]                      m_axis_tuser   // [0] above_threshold,
                                                         // [1] last_of_frame
);
  import bsd3_pkg::*;

  // Configuration registers
  logic [SIZE_W-1:0] grid_q;
  logic [THR_W-1:0]  thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= SIZE_W'(MAX_SIZE);
      thr_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_GRID_SIZE: grid_q <= cfg_data_i[SIZE_W-1:0];
        REG_THRESHOLD: thr_q  <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped grid size
  logic [SIZE_W-1:0] size;
  always_comb begin
    if (grid_q < SIZE_W'(MIN_SIZE)) begin
      size = SIZE_W'(MIN_SIZE);
    end else if (grid_q > SIZE_W'(MAX_SIZE)) begin
      size = SIZE_W'(MAX_SIZE);
    end else begin
      size = grid_q;
    end
  end

  // Pipeline advances whenever the output register is free or drained
  logic out_v_q;
  logic adv;
  logic acc;
  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  // Stage 0: position of the incoming word and window decision
  logic [ADDR_W-1:0] r_q, c_q, r0, c0, r_d, c_d;
  logic [SIZE_W-1:0] r7, c7;
  logic              emit0, lrow0, lfrm0;

  always_comb begin
    r0 = s_axis_tuser ? '0 : r_q;
    c0 = s_axis_tuser ? '0 : c_q;
    r7 = SIZE_W'(r0);
    c7 = SIZE_W'(c0);
    emit0 = (r0 >= ADDR_W'(2)) && (c0 >= ADDR_W'(2)) &&
            (r7 + SIZE_W'(1) <= size) && (c7 + SIZE_W'(1) <= size) && !r0[0] && !c0[0];
    lrow0 = ({1'b0, c7} + (SIZE_W+1)'(3)) > {1'b0, size};
    lfrm0 = lrow0 && (({1'b0, r7} + (SIZE_W+1)'(3)) > {1'b0, size});
    // wrap column, then row
    if (c7 + SIZE_W'(1) >= size) begin
      c_d = '0;
      r_d = (r7 + SIZE_W'(1) >= size) ? '0 : r0 + ADDR_W'(1);
    end else begin
      c_d = c0 + ADDR_W'(1);
      r_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
      c_q <= '0;
    end else if (acc) begin
      r_q <= r_d;
      c_q <= c_d;
    end
  end

  // Stage 1 registers
  logic                v1_q, emit1_q, lrow1_q, lfrm1_q;
  logic [SAMPLE_W-1:0] s1_q;
  logic [ADDR_W-1:0]   c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q    <= s_axis_tdata;
      c1_q    <= c0;
      emit1_q <= emit0;
      lrow1_q <= lrow0;
      lfrm1_q <= lfrm0;
    end
  end

  // Line stores: read at acceptance, rewritten as the word leaves stage 1
  line_word_t rd_word, wr_word;
  logic       shift1;
  assign shift1        = v1_q && adv;
  assign wr_word.older = rd_word.prev;
  assign wr_word.prev  = s1_q;

  bsd3_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc),
    .rd_addr_i (c0),
    .wr_en_i   (shift1),
    .wr_addr_i (c1_q),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word)
  );

  // Window: current column feeds a chain of two column cells (c-1, then c-2)
  col_t              cur_col;
  col_t              cell_col [3];
  logic [COLW_W-1:0] cell_w   [2];
  logic [COLW_W-1:0] cur_w;

  assign cur_col.top = rd_word.older;
  assign cur_col.mid = rd_word.prev;
  assign cur_col.bot = s1_q;
  assign cell_col[0] = cur_col;
  assign cur_w       = col_weight(cur_col);

  for (genvar k = 0; k < 2; k++) begin : g_cell
    bsd3_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift1),
      .col_i   (cell_col[k]),
      .col_o   (cell_col[k+1]),
      .wsum_o  (cell_w[k])
    );
  end

  logic [SUM_W-1:0] sum_d;
  assign sum_d = SUM_W'(cell_w[1]) + (SUM_W'(cell_w[0]) << 2) + SUM_W'(cur_w);

  // Stage 2: weighted sum
  logic             v2_q, lrow2_q, lfrm2_q;
  logic [SUM_W-1:0] sum2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q && emit1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum2_q  <= sum_d;
      lrow2_q <= lrow1_q;
      lfrm2_q <= lfrm1_q;
    end
  end

  // Stage 3: sum/4 times reciprocal of 9
  logic              v3_q, lrow3_q, lfrm3_q;
  logic [PROD_W-1:0] prod3_q;
  logic [QIN_W-1:0]  qin;
  assign qin = sum2_q[SUM_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod3_q <= PROD_W'(qin) * PROD_W'(DIV9_MUL);
      lrow3_q <= lrow2_q;
      lfrm3_q <= lfrm2_q;
    end
  end

  // Output register: quotient and threshold flag
  logic [SAMPLE_W-1:0] quot;
  logic [SAMPLE_W-1:0] data_q;
  logic                above_q, tlast_q, lfrm_q;
  assign quot = prod3_q[DIV9_SHIFT +: SAMPLE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      data_q  <= quot;
      above_q <= quot > thr_q;
      tlast_q <= lrow3_q;
      lfrm_q  <= lfrm3_q;
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = data_q;
  assign m_axis_tlast    = tlast_q;
  assign m_axis_tuser[0] = above_q;
  assign m_axis_tuser[1] = lfrm_q;

  // Checks
  `BSD_ASSERT(a_frame_end_ends_row, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
  `BSD_ASSERT(a_flag_matches_level, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata > thr_q)
  `BSD_ASSERT(a_result_from_stage3, $rose(out_v_q) |-> $past(v3_q))
  `BSD_ASSERT(a_pos_in_grid, c_q < ADDR_W'(MAX_SIZE - 1) || c_q == ADDR_W'(MAX_SIZE - 1))

endmodule

>>> dv/binomial_smooth_decimate_3x3_checker.sv
module binomial_smooth_decimate_3x3_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [bsd3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsd3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample words
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [bsd3_pkg::SAMPLE_W-1:0]   in_data_i,   // [15:0] sample
  input  logic                            in_user_i,   // [0] frame_start
  // result words
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [bsd3_pkg::SAMPLE_W-1:0]   out_data_i,  // [15:0] smoothed
  input  logic                            out_last_i,  // last_in_row
  input  logic [1:0]                      out_user_i,  // [0] above_threshold,
                                                       // [1] last_of_frame
  output int unsigned                     mismatch_count_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bsd3_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic                above;
    logic                row_end;
    logic                frame_end;
  } smooth_result_t;

  // Shadow copy of the filter state
  logic [SIZE_W-1:0]   size_reg;
  logic [THR_W-1:0]    thr_reg;
  logic [SAMPLE_W-1:0] line_older [MAX_SIZE];
  logic [SAMPLE_W-1:0] line_prev  [MAX_SIZE];
  col_t                win_old;   // column c-2
  col_t                win_new;   // column c-1
  int unsigned         row_pos;
  int unsigned         col_pos;

  smooth_result_t      expected_q [$];
  int unsigned         mismatches;

  // Advance the window by one sample; returns 1 when a center completes
  function automatic bit smooth_step(input logic [SAMPLE_W-1:0] smp, input logic restart,
                                     output smooth_result_t res);
    int unsigned span;
    int unsigned r;
    int unsigned c;
    int unsigned weighted;
    col_t        cur;
    bit          hit;
    span = (size_reg < MIN_SIZE) ? MIN_SIZE : (size_reg > MAX_SIZE) ? MAX_SIZE : size_reg;
    if (restart) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;

    // newest column: two stored rows above, incoming sample at the bottom
    cur.top = (c < MAX_SIZE) ? line_older[c] : '0;
    cur.mid = (c < MAX_SIZE) ? line_prev[c] : '0;
    cur.bot = smp;

    // center at odd (r-1, c-1) is complete once (r, c) arrives
    hit = (r >= 2) && (c >= 2) && (r < span) && (c < span) && (r % 2 == 0) && (c % 2 == 0);
    res = '0;
    if (hit) begin
      weighted = win_old.top + win_old.bot + cur.top + cur.bot
               + 4 * (win_old.mid + win_new.top + win_new.bot + cur.mid)
               + 16 * win_new.mid;
      res.smoothed  = SAMPLE_W'(weighted / 36);
      res.above     = res.smoothed > thr_reg;
      res.row_end   = (c + 3 > span);
      res.frame_end = res.row_end && (r + 3 > span);
    end

    win_old = win_new;
    win_new = cur;
    if (c < MAX_SIZE) begin
      line_older[c] = cur.mid;
      line_prev[c]  = smp;
    end

    // raster position, wrapping at the active size
    if (c + 1 >= span) begin
      col_pos = 0;
      row_pos = (r + 1 >= span) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    smooth_result_t got;
    smooth_result_t want;
    smooth_result_t fresh;
    if (!rst_ni) begin
      size_reg = SIZE_W'(MAX_SIZE);
      thr_reg  = '0;
      win_old  = '0;
      win_new  = '0;
      row_pos  = 0;
      col_pos  = 0;
      foreach (line_older[k]) begin
        line_older[k] = '0;
        line_prev[k]  = '0;
      end
      expected_q.delete();
      mismatches = 0;
    end else begin
      // result word: compare against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got.smoothed  = out_data_i;
        got.above     = out_user_i[0];
        got.row_end   = out_last_i;
        got.frame_end = out_user_i[1];
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word: smoothed=%0d above=%0b row_end=%0b frame_end=%0b",
                   $time, got.smoothed, got.above, got.row_end, got.frame_end);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: result mismatch: expected smoothed=%0d above=%0b row_end=%0b %s%0b",
                     $time, want.smoothed, want.above, want.row_end, "frame_end=",
                     want.frame_end);
            $display("%0t:                  actual   smoothed=%0d above=%0b row_end=%0b %s%0b",
                     $time, got.smoothed, got.above, got.row_end, "frame_end=",
                     got.frame_end);
          end
        end
      end

      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_GRID_SIZE: size_reg = cfg_data_i[SIZE_W-1:0];
          REG_THRESHOLD: thr_reg  = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end

      // sample word: predict
      if (in_valid_i && in_ready_i) begin
        if (smooth_step(in_data_i, in_user_i, fresh)) expected_q.push_back(fresh);
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_q.size();
  end

endmodule

>>> dv/binomial_smooth_decimate_3x3_core_tb.sv
module binomial_smooth_decimate_3x3_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsd3_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1050;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned GAP_PCT       = 13;
  localparam int unsigned STEADY_FROM   = 450;
  localparam int unsigned STEADY_TO     = 700;

  // sample value mix for one run of words
  typedef enum logic [1:0] {FILL_ANY, FILL_LOW, FILL_HIGH, FILL_RAIL} fill_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  cfg_reg_e              cfg_index_i   = REG_GRID_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;  // [15:0] sample
  logic                  s_axis_tuser  = 1'b0; // [0] frame_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_axis_tdata;        // [15:0] smoothed
  logic                  m_axis_tlast;        // last_in_row
  logic [1:0]            m_axis_tuser;        // [0] above_threshold, [1] last_of_frame

  logic                  steady        = 1'b0;
  int unsigned           items_sent    = 0;
  int unsigned           cycle_count   = 0;
  int unsigned           mismatch_count;
  int unsigned           pending;

  binomial_smooth_decimate_3x3_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  binomial_smooth_decimate_3x3_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_user_i        (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .out_last_i       (m_axis_tlast),
    .out_user_i       (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always #1 clk_i = ~clk_i;

  // result side backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= GAP_PCT);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample(input fill_e fill);
    case (fill)
      FILL_LOW:  return SAMPLE_W'($urandom_range(0, 255));
      FILL_HIGH: return SAMPLE_W'(16'hFFFF - $urandom_range(0, 255));
      FILL_RAIL: return $urandom_range(0, 1) ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}};
      default:   return SAMPLE_W'($urandom);
    endcase
  endfunction

  // One sample word, with random idle cycles ahead of it
  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic restart);
    steady <= (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);
    while (!steady && $urandom_range(0, 99) < GAP_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Runs stop early once the word budget is spent
  task automatic send_run(input int unsigned count, input bit lead_restart, input bit noisy);
    fill_e fill;
    fill = fill_e'($urandom_range(0, 3));
    for (int unsigned k = 0; k < count && items_sent < ITEM_TARGET; k++)
      push_sample(pick_sample(fill),
                  (k == 0 && lead_restart) || (noisy && $urandom_range(0, 99) < 3));
  endtask

  task automatic set_config(input bit wr_size, input logic [CFG_DATA_W-1:0] size_word,
                            input bit wr_thr, input logic [CFG_DATA_W-1:0] thr_word);
    if (wr_size) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= REG_GRID_SIZE;
      cfg_data_i  <= size_word;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    if (wr_thr) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= REG_THRESHOLD;
      cfg_data_i  <= thr_word;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Hold the sender until every predicted result is out, then let the pipe empty
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned           span;
    int unsigned           raw;
    int unsigned           pick;
    int unsigned           n_frames;
    bit                    wr_size;
    bit                    wr_thr;
    bit                    noisy;
    logic [8:0]            junk;
    logic [CFG_DATA_W-1:0] size_word;
    logic [CFG_DATA_W-1:0] thr_word;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest grid, threshold one below full scale
    set_config(1'b1, CFG_DATA_W'(MIN_SIZE), 1'b1, 16'hFFFE);
    span = MIN_SIZE;
    // all full scale: smoothed is full scale and flagged
    for (int k = 0; k < 9; k++) push_sample(16'hFFFF, k == 0);
    // counters wrapped on their own; three words, then a restart mid-frame
    for (int k = 0; k < 3; k++) push_sample(16'h0000, 1'b0);
    // lone full-scale center, zero elsewhere
    for (int k = 0; k < 9; k++) push_sample((k == 4) ? 16'hFFFF : 16'h0000, k == 0);

    // Random phases; registers change only once the block has drained
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      noisy = ($urandom_range(0, 99) < 15);
      if ($urandom_range(0, 99) < 10) begin
        // shrink mid-grid, stream carries on without a leading restart
        raw = $urandom_range(MIN_SIZE, span);
        set_config(1'b1, CFG_DATA_W'(raw), 1'b0, '0);
        span = raw;
        send_run(span * span * $urandom_range(1, 2), 1'b0, noisy);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      raw = $urandom_range(MIN_SIZE, 8);
        else if (pick < 80) raw = $urandom_range(9, 16);
        else if (pick < 88) raw = $urandom_range(17, MAX_SIZE);
        else if (pick < 94) raw = $urandom_range(0, MIN_SIZE - 1);
        else                raw = $urandom_range(MAX_SIZE + 1, 127);
        // bits above the register width are don't-care
        junk = $urandom_range(0, 1) ? 9'($urandom) : 9'd0;
        size_word = {junk, raw[SIZE_W-1:0]};
        wr_size = ($urandom_range(0, 99) < 85);
        if (wr_size) span = (raw < MIN_SIZE) ? MIN_SIZE : (raw > MAX_SIZE) ? MAX_SIZE : raw;

        pick = $urandom_range(0, 99);
        if (pick < 50)      thr_word = CFG_DATA_W'(32768 - 3000 + $urandom_range(0, 6000));
        else if (pick < 65) thr_word = CFG_DATA_W'($urandom);
        else if (pick < 75) thr_word = '0;
        else if (pick < 85) thr_word = 16'hFFFF;
        else                thr_word = CFG_DATA_W'($urandom_range(0, 300));
        wr_thr = ($urandom_range(0, 99) < 60);
        set_config(wr_size, size_word, wr_thr, thr_word);

        // small grids run whole; large ones are cut short by the next restart
        if (span <= 16) begin
          n_frames = (span <= 8) ? $urandom_range(1, 3) : 1;
          repeat (n_frames) send_run(span * span, 1'b1, noisy);
        end else begin
          send_run(span * $urandom_range(3, 4) + $urandom_range(0, span - 1), 1'b1, noisy);
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
